@@ sv/qmd_pkg.sv @@
// Shared types and constants for the Q16.16 multiply/divide unit.
// Used by every module of the block; depends on nothing else.
package qmd_pkg;

    localparam int unsigned DATA_W          = 32;
    localparam int unsigned FRAC_W          = 16;
    localparam int unsigned MUL_HI          = 47;
    localparam int unsigned GUARD_SHIFT     = 14;
    localparam int unsigned DIV_STEPS       = 48;
    localparam int unsigned STEPS_PER_STAGE = 2;
    localparam int unsigned DIV_STAGES      = DIV_STEPS / STEPS_PER_STAGE;

    localparam logic [DATA_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SAT_NEG = 32'h8000_0000;

    typedef enum logic {
        OP_MUL = 1'b0,
        OP_DIV = 1'b1
    } op_t;

    // One item in flight: the product rides along untouched while the
    // divider fields advance two quotient bits per stage.
    typedef struct packed {
        op_t               op;
        logic              neg;
        logic              sat;
        logic [DATA_W-1:0] prod;
        logic [DATA_W-1:0] num;
        logic [DATA_W-1:0] den;
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] quo;
    } slot_t;

endpackage

@@ sv/q16_16_mul_div_unit.sv @@
// Top level of the signed Q16.16 multiply/divide unit.
// Depends on qmd_pkg, qmd_front, qmd_div_stage and qmd_back.
//
// Usage:
// An item enters on valid/ready with op (0 multiply, 1 divide) and two
// signed Q16.16 operands; one result leaves on result_valid/result_ready.
// Every item, multiply or divide, passes through the same 26 register
// stages: one entry stage (magnitudes, guard, 32x32 product), 24 divider
// stages of two restoring steps each, and the output register. With the
// receiver ready the unit takes one item every cycle. The 48-step long
// division sets the depth.
// Each stage holds at most one item and takes a new one whenever it is
// empty or its item moves on, so a stalled receiver only blocks input once
// every stage is full; empty stages keep filling meanwhile. Items leave in
// the order they entered. Reset empties all stages; the unit has no other
// state and is ready in the first cycle after reset.
module q16_16_mul_div_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       valid,
    output logic                       ready,
    input  logic                       op,
    input  logic [qmd_pkg::DATA_W-1:0] operand_a,
    input  logic [qmd_pkg::DATA_W-1:0] operand_b,
    output logic                       result_valid,
    input  logic                       result_ready,
    output logic [qmd_pkg::DATA_W-1:0] result
);

    qmd_pkg::slot_t                    stage_slot [0:qmd_pkg::DIV_STAGES];
    logic [qmd_pkg::DIV_STAGES:0]      stage_valid;
    logic [qmd_pkg::DIV_STAGES:0]      stage_ready;

    qmd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (valid),
        .in_ready  (ready),
        .op        (op),
        .a         (operand_a),
        .b         (operand_b),
        .out_valid (stage_valid[0]),
        .out_ready (stage_ready[0]),
        .out_slot  (stage_slot[0])
    );

    for (genvar g = 0; g < qmd_pkg::DIV_STAGES; g++)
    begin : g_div
        qmd_div_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[g]),
            .in_ready  (stage_ready[g]),
            .in_slot   (stage_slot[g]),
            .out_valid (stage_valid[g+1]),
            .out_ready (stage_ready[g+1]),
            .out_slot  (stage_slot[g+1])
        );
    end

    qmd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (stage_valid[qmd_pkg::DIV_STAGES]),
        .in_ready   (stage_ready[qmd_pkg::DIV_STAGES]),
        .in_slot    (stage_slot[qmd_pkg::DIV_STAGES]),
        .out_valid  (result_valid),
        .out_ready  (result_ready),
        .out_result (result)
    );

`ifndef SYNTHESIS
    // With every stage full and the receiver stalled, no item may enter.
    a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready && (&stage_valid) |-> !ready)
        else $error("input accepted while the whole pipeline is stalled and full");

    // An empty pipeline always takes an item.
    a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !(|stage_valid) |-> ready)
        else $error("empty pipeline refused an item");

    // An accepted item is held by the entry stage in the next cycle.
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        valid && ready |=> stage_valid[0])
        else $error("accepted item did not reach the entry stage");

    // The last divider stage keeps its item intact while the output is blocked.
    a_last_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid[qmd_pkg::DIV_STAGES] && !stage_ready[qmd_pkg::DIV_STAGES]
        |=> stage_valid[qmd_pkg::DIV_STAGES] && $stable(stage_slot[qmd_pkg::DIV_STAGES]))
        else $error("divider item lost or changed during a stall");
`endif

endmodule

@@ sv/qmd_front.sv @@
// Entry stage: operand magnitudes, overflow guard and the signed product.
// Depends on qmd_pkg.
module qmd_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       op,
    input  logic [qmd_pkg::DATA_W-1:0] a,
    input  logic [qmd_pkg::DATA_W-1:0] b,
    output logic                       out_valid,
    input  logic                       out_ready,
    output qmd_pkg::slot_t             out_slot
);

    logic signed [2*qmd_pkg::DATA_W-1:0] product;
    logic [qmd_pkg::DATA_W-1:0]          mag_a;
    logic [qmd_pkg::DATA_W-1:0]          mag_b;
    logic signed [qmd_pkg::DATA_W-1:0]   guard_lhs;
    qmd_pkg::slot_t                      slot_next;
    qmd_pkg::slot_t                      slot_reg;
    logic                                valid_reg;

    assign product = (2*qmd_pkg::DATA_W)'($signed(a)) * (2*qmd_pkg::DATA_W)'($signed(b));

    // Magnitudes wrap, so the most negative value keeps its sign bit and
    // takes part in the guard compare as a negative number.
    assign mag_a     = a[qmd_pkg::DATA_W-1] ? (qmd_pkg::DATA_W'(0) - a) : a;
    assign mag_b     = b[qmd_pkg::DATA_W-1] ? (qmd_pkg::DATA_W'(0) - b) : b;
    assign guard_lhs = $signed(mag_a) >>> qmd_pkg::GUARD_SHIFT;

    always_comb
    begin
        slot_next      = '0;
        slot_next.op   = qmd_pkg::op_t'(op);
        slot_next.neg  = a[qmd_pkg::DATA_W-1] ^ b[qmd_pkg::DATA_W-1];
        slot_next.sat  = guard_lhs >= $signed(mag_b);
        slot_next.prod = product[qmd_pkg::MUL_HI:qmd_pkg::FRAC_W];
        slot_next.num  = mag_a;
        slot_next.den  = mag_b;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            slot_reg <= slot_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_slot  = slot_reg;

endmodule

@@ sv/qmd_div_stage.sv @@
// One divider stage: a few steps of restoring long division on an item.
// Depends on qmd_pkg.
module qmd_div_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  qmd_pkg::slot_t in_slot,
    output logic           out_valid,
    input  logic           out_ready,
    output qmd_pkg::slot_t out_slot
);

    qmd_pkg::slot_t slot_next;
    qmd_pkg::slot_t slot_reg;
    logic           valid_reg;

    always_comb
    begin
        logic [qmd_pkg::DATA_W-1:0] rem;
        logic [qmd_pkg::DATA_W-1:0] num;
        logic [qmd_pkg::DATA_W-1:0] quo;
        logic [qmd_pkg::DATA_W:0]   trial;
        slot_next = in_slot;
        rem       = in_slot.rem;
        num       = in_slot.num;
        quo       = in_slot.quo;
        // Dividend bits enter from the top of num; zeros follow once the
        // magnitude is used up, which supplies the sixteen fraction bits.
        for (int s = 0; s < qmd_pkg::STEPS_PER_STAGE; s++)
        begin
            trial = {rem, num[qmd_pkg::DATA_W-1]};
            num   = {num[qmd_pkg::DATA_W-2:0], 1'b0};
            if (trial >= {1'b0, in_slot.den})
            begin
                trial = trial - {1'b0, in_slot.den};
                quo   = {quo[qmd_pkg::DATA_W-2:0], 1'b1};
            end
            else
            begin
                quo   = {quo[qmd_pkg::DATA_W-2:0], 1'b0};
            end
            rem = trial[qmd_pkg::DATA_W-1:0];
        end
        slot_next.rem = rem;
        slot_next.num = num;
        slot_next.quo = quo;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            slot_reg <= slot_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_slot  = slot_reg;

endmodule

@@ sv/qmd_back.sv @@
// Result stage: sign fix-up, saturation and selection, into the output register.
// Depends on qmd_pkg.
module qmd_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  qmd_pkg::slot_t             in_slot,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [qmd_pkg::DATA_W-1:0] out_result
);

    logic [qmd_pkg::DATA_W-1:0] result_next;
    logic [qmd_pkg::DATA_W-1:0] result_reg;
    logic                       valid_reg;

    always_comb
    begin
        case (in_slot.op)
            qmd_pkg::OP_DIV:
            begin
                if (in_slot.sat)
                begin
                    result_next = in_slot.neg ? qmd_pkg::SAT_NEG : qmd_pkg::SAT_POS;
                end
                else if (in_slot.neg)
                begin
                    result_next = qmd_pkg::DATA_W'(0) - in_slot.quo;
                end
                else
                begin
                    result_next = in_slot.quo;
                end
            end
            default:
            begin
                result_next = in_slot.prod;
            end
        endcase
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

@@ tb/sv/tb_q16_16_mul_div_unit.sv @@
// Self-checking testbench for the signed Q16.16 multiply/divide unit.
// Holds a result checker class and the top module; depends on qmd_pkg and the RTL.

class qmd_checker;
    logic [qmd_pkg::DATA_W-1:0] pending_results[$];
    int unsigned mismatches;
    int unsigned results_checked;
    int unsigned mul_items;
    int unsigned div_items;

    function automatic logic [qmd_pkg::DATA_W-1:0] fixed_point_result(
        qmd_pkg::op_t op, logic [31:0] a, logic [31:0] b);
        logic signed [63:0] wide_a;
        logic signed [63:0] wide_b;
        logic signed [63:0] product;
        logic [31:0] mag_a;
        logic [31:0] mag_b;
        logic signed [31:0] guard_lhs;
        logic [47:0] dividend;
        logic [47:0] wide_q;
        logic [31:0] quo;
        logic negative;
        if (op == qmd_pkg::OP_MUL)
        begin
            wide_a = {{32{a[31]}}, a};
            wide_b = {{32{b[31]}}, b};
            product = wide_a * wide_b;
            return product[qmd_pkg::MUL_HI:qmd_pkg::FRAC_W];
        end
        negative = a[31] ^ b[31];
        // Magnitudes wrap, so the most negative value keeps its sign bit.
        mag_a = a[31] ? (~a + 32'd1) : a;
        mag_b = b[31] ? (~b + 32'd1) : b;
        guard_lhs = $signed(mag_a) >>> qmd_pkg::GUARD_SHIFT;
        if (guard_lhs >= $signed(mag_b))
            return negative ? qmd_pkg::SAT_NEG : qmd_pkg::SAT_POS;
        // A zero divisor only gets this far with the most negative dividend.
        if (mag_b == 32'd0)
            quo = '1;
        else
        begin
            dividend = {mag_a, 16'h0000};
            wide_q = dividend / {16'h0000, mag_b};
            quo = wide_q[31:0];
        end
        return negative ? (~quo + 32'd1) : quo;
    endfunction

    function void note_item(qmd_pkg::op_t op, logic [31:0] a, logic [31:0] b);
        if (op == qmd_pkg::OP_MUL)
            mul_items++;
        else
            div_items++;
        pending_results.push_back(fixed_point_result(op, a, b));
    endfunction

    function void check_result(logic [31:0] actual);
        logic [31:0] wanted;
        results_checked++;
        if (pending_results.size() == 0)
        begin
            if (mismatches < 10)
                $display("[%0t] unexpected result %h with nothing outstanding", $time, actual);
            mismatches++;
            return;
        end
        wanted = pending_results.pop_front();
        if (wanted !== actual)
        begin
            if (mismatches < 10)
                $display("[%0t] result mismatch: expected %h, got %h", $time, wanted, actual);
            mismatches++;
        end
    endfunction

    function int unsigned outstanding();
        return pending_results.size();
    endfunction
endclass

module tb_q16_16_mul_div_unit;
    timeunit 1ns;
    timeprecision 1ps;

    // The longest quiet stretch of a correct run is the output hold-off
    // plus the pipeline depth; the limit allows several times that.
    localparam int HOLD_CYCLES    = 300;
    localparam int END_CYCLES     = 60;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                       clk;
    logic                       rst_n        = 1'b0;
    logic                       valid        = 1'b0;
    logic                       ready;
    logic                       op           = 1'b0;
    logic [qmd_pkg::DATA_W-1:0] operand_a    = '0;
    logic [qmd_pkg::DATA_W-1:0] operand_b    = '0;
    logic                       result_valid;
    logic                       result_ready = 1'b0;
    logic [qmd_pkg::DATA_W-1:0] result;

    qmd_checker book;
    bit idle_on      = 1'b1;
    bit hold_off_req = 1'b0;
    int idle_cycles  = 0;

    q16_16_mul_div_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .valid        (valid),
        .ready        (ready),
        .op           (op),
        .operand_a    (operand_a),
        .operand_b    (operand_b),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Handshakes are sampled at the falling edge, where every input driven
    // at the previous rising edge has settled; they complete at the next one.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (valid && ready)
                book.note_item(qmd_pkg::op_t'(op), operand_a, operand_b);
            if (result_valid && result_ready)
                book.check_result(result);
            if ((valid && ready) || (result_valid && result_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    initial
    begin : watchdog
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("Timed out after %0d cycles without a handshake", WATCHDOG_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin : result_sink
        int stall;
        logic got;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = idle_on ? $urandom_range(0, 3) : 0;
            if (hold_off_req)
            begin
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            do
            begin
                @(negedge clk);
                got = result_valid;
                @(posedge clk);
            end
            while (!got);
        end
    end

    task automatic send_item(input qmd_pkg::op_t o, input logic [31:0] a,
                             input logic [31:0] b);
        int gap;
        logic took;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap > 0)
        begin
            valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        valid     <= 1'b1;
        op        <= o;
        operand_a <= a;
        operand_b <= b;
        do
        begin
            @(negedge clk);
            took = ready;
            @(posedge clk);
        end
        while (!took);
    endtask

    // Sender stops offering items until every outstanding result is back.
    task automatic drain_results();
        valid <= 1'b0;
        while (book.outstanding() != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] random_operand();
        logic [31:0] v;
        int sel;
        sel = $urandom_range(0, 7);
        case (sel)
            0, 1, 2: v = $urandom;
            3, 4:    v = $urandom >> $urandom_range(0, 31);
            5:       v = $urandom_range(0, 32'h0020_0000);
            6:
            begin
                case ($urandom_range(0, 5))
                    0:       v = 32'h0000_0000;
                    1:       v = qmd_pkg::SAT_POS;
                    2:       v = qmd_pkg::SAT_NEG;
                    3:       v = 32'h0001_0000;
                    4:       v = 32'hFFFF_FFFF;
                    default: v = 32'h0000_0001;
                endcase
            end
            default: v = {16'($urandom_range(0, 15)), 16'h0000};
        endcase
        if (sel >= 3 && sel != 6 && $urandom_range(0, 1) == 1)
            v = ~v + 32'd1;
        return v;
    endfunction

    task automatic send_random(input int count);
        qmd_pkg::op_t o;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] mag;
        for (int k = 0; k < count; k++)
        begin
            o = ($urandom_range(0, 1) == 1) ? qmd_pkg::OP_DIV : qmd_pkg::OP_MUL;
            a = random_operand();
            b = random_operand();
            // Put a quarter of the divides right at the saturation boundary.
            if (o == qmd_pkg::OP_DIV && $urandom_range(0, 3) == 0)
            begin
                mag = a[31] ? (~a + 32'd1) : a;
                b = (mag >> qmd_pkg::GUARD_SHIFT) + $urandom_range(0, 2) - 32'd1;
                if ($urandom_range(0, 1) == 1)
                    b = ~b + 32'd1;
            end
            send_item(o, a, b);
        end
    endtask

    initial
    begin : stimulus
        book = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Multiply extremes and signs.
        send_item(qmd_pkg::OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_item(qmd_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000);
        send_item(qmd_pkg::OP_MUL, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(qmd_pkg::OP_MUL, 32'h0001_0000, 32'hFFFF_0000);
        send_item(qmd_pkg::OP_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(qmd_pkg::OP_MUL, 32'h0000_0000, 32'h8000_0000);
        send_item(qmd_pkg::OP_MUL, 32'h0001_8000, 32'h0002_8000);
        // Zero divisors, including the most negative dividend that slips past the guard.
        send_item(qmd_pkg::OP_DIV, 32'h0001_0000, 32'h0000_0000);
        send_item(qmd_pkg::OP_DIV, 32'hFFFF_0000, 32'h0000_0000);
        send_item(qmd_pkg::OP_DIV, 32'h0000_0000, 32'h0000_0000);
        send_item(qmd_pkg::OP_DIV, 32'h8000_0000, 32'h0000_0000);
        // Most negative divisor always saturates.
        send_item(qmd_pkg::OP_DIV, 32'h0001_0000, 32'h8000_0000);
        send_item(qmd_pkg::OP_DIV, 32'h8000_0000, 32'h8000_0000);
        // Most negative dividend with ordinary divisors; upper quotient bits drop.
        send_item(qmd_pkg::OP_DIV, 32'h8000_0000, 32'h0001_0000);
        send_item(qmd_pkg::OP_DIV, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(qmd_pkg::OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
        // Guard boundary and ordinary quotients.
        send_item(qmd_pkg::OP_DIV, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_item(qmd_pkg::OP_DIV, 32'h7FFF_FFFF, 32'h0001_FFFF);
        send_item(qmd_pkg::OP_DIV, 32'h7FFF_FFFF, 32'h0002_0000);
        send_item(qmd_pkg::OP_DIV, 32'hFFFF_FFFF, 32'h0000_0001);
        send_item(qmd_pkg::OP_DIV, 32'h0003_0000, 32'hFFFE_0000);
        send_item(qmd_pkg::OP_DIV, 32'h0001_0000, 32'h0003_0000);
        send_item(qmd_pkg::OP_DIV, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(qmd_pkg::OP_DIV, 32'h0000_0001, 32'h7FFF_FFFF);
        drain_results();

        idle_on = 1'b1;
        send_random(600);
        drain_results();

        idle_on = 1'b0;
        send_random(400);

        // Output held off while the sender keeps offering items.
        hold_off_req = 1'b1;
        send_random(150);

        idle_on = 1'b1;
        send_random(750);
        drain_results();
        repeat (END_CYCLES) @(posedge clk);

        $display("Checked %0d results from %0d multiplies and %0d divides.",
                 book.results_checked, book.mul_items, book.div_items);
        $display("Run covered edge operands, back-to-back traffic, a %0d-cycle output stall "
                 , HOLD_CYCLES, "and full drains.");
        if (book.mismatches == 0 && book.outstanding() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
